// ===== hdl/krtp_pkg.sv =====
// ----------------------------------------------------------------------------
// krtp_pkg
// Shared types, character codes and the byte classifier for the keyed
// record text parser.
// ----------------------------------------------------------------------------
package krtp_pkg;

  typedef enum logic [3:0] {
    PH_START      = 4'd0,
    PH_NAME       = 4'd1,
    PH_OPEN_REC   = 4'd2,
    PH_ID_LEAD    = 4'd3,
    PH_ID         = 4'd4,
    PH_SEP        = 4'd5,
    PH_FNAME_LEAD = 4'd6,
    PH_FNAME      = 4'd7,
    PH_EQUAL      = 4'd8,
    PH_OPEN_VAL   = 4'd9,
    PH_VALUE      = 4'd10,
    PH_AFTER_VAL  = 4'd11
  } phase_t;

  typedef enum logic [3:0] {
    EV_NAME_CH  = 4'd0,
    EV_NAME_END = 4'd1,
    EV_ID_CH    = 4'd2,
    EV_ID_END   = 4'd3,
    EV_FN_CH    = 4'd4,
    EV_FN_END   = 4'd5,
    EV_VAL_CH   = 4'd6,
    EV_VAL_END  = 4'd7,
    EV_REC_END  = 4'd8,
    EV_CLEAN    = 4'd9,
    EV_SYNTAX   = 4'd10,
    EV_TRUNC    = 4'd11
  } event_t;

  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_NUL    = 8'h00;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef struct packed {
    logic [7:0] ch;
    logic       eos;
    logic       sp;
    logic       word;
    logic       idch;
  } tok_t;

  typedef struct packed {
    event_t     kind;
    logic [7:0] ch;
  } res_t;

  typedef struct packed {
    logic err;
    logic res_push;
  } stat_t;

  function automatic tok_t classify(input logic [7:0] c, input logic eos);
    tok_t t;
    t.ch  = c;
    t.eos = eos;
    case (c) inside
      CH_SPACE, CH_TAB, CH_NL: t.sp = 1'b1;
      default:                 t.sp = 1'b0;
    endcase
    case (c) inside
      [8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39], CH_UNDER: t.word = 1'b1;
      default:                                             t.word = 1'b0;
    endcase
    case (c) inside
      CH_MINUS, CH_PLUS, CH_DOT: t.idch = 1'b1;
      default:                   t.idch = t.word;
    endcase
    return t;
  endfunction

endpackage

// ===== hdl/keyed_record_text_parser_unit.sv =====
// A byte's token is registered in the input queue, and its event in the result queue.
// Throughput: one byte per cycle while the result queue is not full.
// Both sides hold two-entry queues; a full result queue stops the phase machine and backs up into the input queue.
// Reset: synchronous, active low; clears both queues, the phase (record start),
// the escape, comment and error flags.
// ----------------------------------------------------------------------------
// keyed_record_text_parser_unit
// Streaming parser for @name{id, fname={value}, ...} text, one byte per
// transfer, one event or none per byte.
// ----------------------------------------------------------------------------
module keyed_record_text_parser_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_stream,
  output logic       empty,
  input  logic       pop,
  output logic [3:0] out_event_kind,
  output logic [7:0] out_char_value
);
  import krtp_pkg::*;

  logic  tok_valid;
  tok_t  tok;
  logic  tok_pop;
  stat_t stat;

  krtp_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_byte          (in_byte),
    .in_end_of_stream (in_end_of_stream),
    .tok_valid        (tok_valid),
    .tok              (tok),
    .tok_pop          (tok_pop)
  );

  krtp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .tok_valid      (tok_valid),
    .tok            (tok),
    .tok_pop        (tok_pop),
    .empty          (empty),
    .pop            (pop),
    .out_event_kind (out_event_kind),
    .out_char_value (out_char_value),
    .stat           (stat)
  );

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    stat.err |=> stat.err)
    else $error("error flag cleared without reset");

  a_err_silent: assert property (@(posedge clk) disable iff (!rst_n)
    stat.err |-> !stat.res_push)
    else $error("event queued after error");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> (empty && !full))
    else $error("queues not empty after reset");

  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_event_kind != EV_NAME_CH && out_event_kind != EV_ID_CH &&
     out_event_kind != EV_FN_CH && out_event_kind != EV_VAL_CH)
    |-> (out_char_value == CH_NUL))
    else $error("non-character event carries a character");

endmodule

// ===== hdl/krtp_front.sv =====
// ----------------------------------------------------------------------------
// krtp_front
// Input side: classifies each byte and holds the tokens in a two-entry
// queue toward the phase machine.
// ----------------------------------------------------------------------------
module krtp_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  output logic           full,
  input  logic [7:0]     in_byte,
  input  logic           in_end_of_stream,
  output logic           tok_valid,
  output krtp_pkg::tok_t tok,
  input  logic           tok_pop
);
  import krtp_pkg::*;

  tok_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign full      = (cnt_r == QCNT_W'(QDEPTH));
  assign tok_valid = (cnt_r != '0);
  assign tok       = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = tok_pop && tok_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= classify(in_byte, in_end_of_stream);
    end
  end

endmodule

// ===== hdl/krtp_back.sv =====
// ----------------------------------------------------------------------------
// krtp_back
// Phase machine: consumes classified tokens, tracks escape, comment and
// error state, and queues the events in a two-entry result queue.
// ----------------------------------------------------------------------------
module krtp_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            tok_valid,
  input  krtp_pkg::tok_t  tok,
  output logic            tok_pop,
  output logic            empty,
  input  logic            pop,
  output logic [3:0]      out_event_kind,
  output logic [7:0]      out_char_value,
  output krtp_pkg::stat_t stat
);
  import krtp_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic              esc_r, esc_nxt;
  logic              com_r, com_nxt;
  logic              err_r, err_nxt;
  logic              ev_vld;
  event_t            ev_kind;
  logic              ev_chr;
  logic              step;

  res_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              res_push;
  logic              res_pop;
  res_t              res_head;

  assign step    = tok_valid && (cnt_r != QCNT_W'(QDEPTH));
  assign tok_pop = step;

  // next state
  always_comb begin
    phase_nxt = phase_r;
    esc_nxt   = esc_r;
    com_nxt   = com_r;
    err_nxt   = err_r;
    if (err_r) begin
      phase_nxt = phase_r;
    end else if (tok.eos) begin
      com_nxt = 1'b0;
      if (!(phase_r == PH_START && !esc_r)) begin
        esc_nxt = 1'b0;
        err_nxt = 1'b1;
      end
    end else if (com_r) begin
      if (tok.ch == CH_NL) begin
        com_nxt = 1'b0;
      end
    end else if (phase_r == PH_VALUE && esc_r) begin
      esc_nxt = 1'b0;
    end else if (tok.ch == CH_PCT) begin
      com_nxt = 1'b1;
    end else begin
      case (phase_r)
        PH_NAME: begin
          if (tok.ch == CH_LBRACE) phase_nxt = PH_ID_LEAD;
          else if (tok.sp) phase_nxt = PH_OPEN_REC;
          else if (!tok.word) err_nxt = 1'b1;
        end
        PH_OPEN_REC: begin
          if (tok.ch == CH_LBRACE) phase_nxt = PH_ID_LEAD;
          else if (!tok.sp) err_nxt = 1'b1;
        end
        PH_ID_LEAD, PH_ID: begin
          if (tok.idch) phase_nxt = PH_ID;
          else if (tok.sp) begin
            if (phase_r == PH_ID) phase_nxt = PH_SEP;
          end else if (tok.ch == CH_COMMA) phase_nxt = PH_FNAME_LEAD;
          else err_nxt = 1'b1;
        end
        PH_SEP: begin
          if (tok.ch == CH_COMMA) phase_nxt = PH_FNAME_LEAD;
          else if (!tok.sp) err_nxt = 1'b1;
        end
        PH_FNAME_LEAD, PH_FNAME: begin
          if (tok.word) phase_nxt = PH_FNAME;
          else if (tok.sp) begin
            if (phase_r == PH_FNAME) phase_nxt = PH_EQUAL;
          end else if (tok.ch == CH_EQ) phase_nxt = PH_OPEN_VAL;
          else err_nxt = 1'b1;
        end
        PH_EQUAL: begin
          if (tok.ch == CH_EQ) phase_nxt = PH_OPEN_VAL;
          else if (!tok.sp) err_nxt = 1'b1;
        end
        PH_OPEN_VAL: begin
          if (tok.ch == CH_LBRACE) phase_nxt = PH_VALUE;
          else if (!tok.sp) err_nxt = 1'b1;
        end
        PH_VALUE: begin
          if (tok.ch == CH_BSLASH) esc_nxt = 1'b1;
          else if (tok.ch == CH_RBRACE) phase_nxt = PH_AFTER_VAL;
          else if (tok.ch == CH_LBRACE || tok.ch == CH_NUL) err_nxt = 1'b1;
        end
        PH_AFTER_VAL: begin
          if (tok.ch == CH_COMMA) phase_nxt = PH_FNAME_LEAD;
          else if (tok.ch == CH_RBRACE) phase_nxt = PH_START;
          else if (!tok.sp) err_nxt = 1'b1;
        end
        default: begin
          if (tok.ch == CH_AT) phase_nxt = PH_NAME;
          else if (!tok.sp) err_nxt = 1'b1;
        end
      endcase
    end
  end

  // outputs
  always_comb begin
    ev_vld  = 1'b0;
    ev_kind = EV_SYNTAX;
    ev_chr  = 1'b0;
    if (err_r) begin
      ev_vld = 1'b0;
    end else if (tok.eos) begin
      ev_vld  = 1'b1;
      ev_kind = (phase_r == PH_START && !esc_r) ? EV_CLEAN : EV_TRUNC;
    end else if (com_r) begin
      ev_vld = 1'b0;
    end else if (phase_r == PH_VALUE && esc_r) begin
      ev_vld  = (tok.ch != CH_NL);
      ev_kind = EV_VAL_CH;
      ev_chr  = 1'b1;
    end else if (tok.ch == CH_PCT) begin
      ev_vld = 1'b0;
    end else begin
      case (phase_r)
        PH_NAME: begin
          if (tok.word) begin
            ev_vld = 1'b1; ev_kind = EV_NAME_CH; ev_chr = 1'b1;
          end else if (tok.ch == CH_LBRACE || tok.sp) begin
            ev_vld = 1'b1; ev_kind = EV_NAME_END;
          end else begin
            ev_vld = 1'b1;
          end
        end
        PH_ID_LEAD, PH_ID: begin
          if (tok.idch) begin
            ev_vld = 1'b1; ev_kind = EV_ID_CH; ev_chr = 1'b1;
          end else if (tok.sp) begin
            ev_vld = (phase_r == PH_ID); ev_kind = EV_ID_END;
          end else if (tok.ch == CH_COMMA) begin
            ev_vld = 1'b1; ev_kind = EV_ID_END;
          end else begin
            ev_vld = 1'b1;
          end
        end
        PH_FNAME_LEAD, PH_FNAME: begin
          if (tok.word) begin
            ev_vld = 1'b1; ev_kind = EV_FN_CH; ev_chr = 1'b1;
          end else if (tok.sp) begin
            ev_vld = (phase_r == PH_FNAME); ev_kind = EV_FN_END;
          end else if (tok.ch == CH_EQ) begin
            ev_vld = 1'b1; ev_kind = EV_FN_END;
          end else begin
            ev_vld = 1'b1;
          end
        end
        PH_OPEN_REC: ev_vld = !(tok.sp || tok.ch == CH_LBRACE);
        PH_SEP:      ev_vld = !(tok.sp || tok.ch == CH_COMMA);
        PH_EQUAL:    ev_vld = !(tok.sp || tok.ch == CH_EQ);
        PH_OPEN_VAL: ev_vld = !(tok.sp || tok.ch == CH_LBRACE);
        PH_VALUE: begin
          if (tok.ch == CH_BSLASH) begin
            ev_vld = 1'b0;
          end else if (tok.ch == CH_RBRACE) begin
            ev_vld = 1'b1; ev_kind = EV_VAL_END;
          end else if (tok.ch == CH_LBRACE || tok.ch == CH_NUL) begin
            ev_vld = 1'b1;
          end else begin
            ev_vld = 1'b1; ev_kind = EV_VAL_CH; ev_chr = 1'b1;
          end
        end
        PH_AFTER_VAL: begin
          if (tok.ch == CH_RBRACE) begin
            ev_vld = 1'b1; ev_kind = EV_REC_END;
          end else begin
            ev_vld = !(tok.sp || tok.ch == CH_COMMA);
          end
        end
        default: ev_vld = !(tok.sp || tok.ch == CH_AT);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      esc_r   <= 1'b0;
      com_r   <= 1'b0;
      err_r   <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      esc_r   <= esc_nxt;
      com_r   <= com_nxt;
      err_r   <= err_nxt;
    end
  end

  // result queue
  assign res_push       = step && ev_vld;
  assign res_pop        = pop && !empty;
  assign empty          = (cnt_r == '0);
  assign res_head       = mem_r[rd_ptr_r];
  assign out_event_kind = res_head.kind;
  assign out_char_value = res_head.ch;
  assign stat.err       = err_r;
  assign stat.res_push  = res_push;

  always_comb begin
    wr_ptr_nxt = res_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = res_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(res_push) - QCNT_W'(res_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      mem_r[wr_ptr_r] <= '{kind: ev_kind, ch: (ev_chr ? tok.ch : CH_NUL)};
    end
  end

endmodule
